// ===== src/spaced_time_ordered_set_defines.svh =====
// Assertion macros used by the checker file of the spaced time set.
`ifndef SPACED_TIME_ORDERED_SET_DEFINES_SVH
`define SPACED_TIME_ORDERED_SET_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define STOS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define STOS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/stos_pkg.sv =====
// Shared constants and codes of the spaced time-ordered set.
`default_nettype none
package stos_pkg;

   localparam int CAPACITY_DEF = 32;

   localparam int ACTION_W = 4;
   localparam int HHMM_W   = 14;
   localparam int GAP_W    = 11;
   localparam int MIN_W    = 11;
   localparam int STATUS_W = 3;
   localparam int TOUT_W   = 12;
   localparam int RANK_W   = 6;

   // Actions
   localparam logic [ACTION_W-1:0] ACT_ADD    = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_CANCEL = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_LAND   = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_MIN    = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_MAX    = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_NEXT   = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_RANK   = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_LIST   = 4'd8;

   // Result status
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_FMT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SPACING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFND  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

   // Reciprocal constants for divide by 100 (14-bit key) and by 60 (minute)
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_100_SH = 19;
   localparam logic [10:0] RECIP_60    = 11'd1093;
   localparam int          RECIP_60_SH  = 16;

endpackage
`default_nettype wire

// ===== src/stos_req_if.sv =====
// Command channel: action and HHMM time.
`default_nettype none
interface stos_req_if;
   logic                           valid;
   logic                           ready;
   logic [stos_pkg::ACTION_W-1:0]  action;
   logic [stos_pkg::HHMM_W-1:0]    time_hhmm;

   modport source (output valid, output action, output time_hhmm, input ready);
   modport sink   (input valid, input action, input time_hhmm, output ready);
endinterface
`default_nettype wire

// ===== src/stos_rsp_if.sv =====
// Result channel: status, time, rank and last flag.
`default_nettype none
interface stos_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [stos_pkg::STATUS_W-1:0]  status;
   logic [stos_pkg::TOUT_W-1:0]    time_out;
   logic [stos_pkg::RANK_W-1:0]    rank_count;
   logic                           last;

   modport source (output valid, output status, output time_out, output rank_count,
                   output last, input ready);
   modport sink   (input valid, input status, input time_out, input rank_count,
                   input last, output ready);
endinterface
`default_nettype wire

// ===== src/stos_csr_if.sv =====
// Configuration write channel carrying the minimum gap.
`default_nettype none
interface stos_csr_if;
   logic                        valid;
   logic                        ready;
   logic [stos_pkg::GAP_W-1:0]  min_gap;

   modport source (output valid, output min_gap, input ready);
   modport sink   (input valid, input min_gap, output ready);
endinterface
`default_nettype wire

// ===== src/stos_mem.sv =====
// Time store: one write port, one registered read port.
`default_nettype none
module stos_mem #(
   parameter int DEPTH = stos_pkg::CAPACITY_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [stos_pkg::MIN_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [stos_pkg::MIN_W-1:0] rd_data
);

   logic [stos_pkg::MIN_W-1:0] mem [DEPTH];

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/stos_core.sv =====
// Command sequencer: walks the store one entry per read and shifts entries.
`default_nettype none
module stos_core #(
   parameter int CAPACITY = stos_pkg::CAPACITY_DEF,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [stos_pkg::GAP_W-1:0]  min_gap,
   stos_req_if.sink                         req_chan,
   stos_rsp_if.source                       rsp_chan,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic [stos_pkg::MIN_W-1:0]       wr_data,
   output logic [AW-1:0]                    rd_addr,
   input  wire logic [stos_pkg::MIN_W-1:0]  rd_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEC  = 4'd1;
   localparam logic [3:0] S_DEC2 = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_EV   = 4'd4;
   localparam logic [3:0] S_ACHK = 4'd5;
   localparam logic [3:0] S_SHR  = 4'd6;
   localparam logic [3:0] S_SHW  = 4'd7;
   localparam logic [3:0] S_INS  = 4'd8;
   localparam logic [3:0] S_SHL  = 4'd9;
   localparam logic [3:0] S_SLW  = 4'd10;
   localparam logic [3:0] S_CV1  = 4'd11;
   localparam logic [3:0] S_CV2  = 4'd12;
   localparam logic [3:0] S_OUT  = 4'd13;

   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   logic [3:0]                     state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [stos_pkg::ACTION_W-1:0]  act_ff, act_in;
   logic [stos_pkg::HHMM_W-1:0]    key_ff, key_in;
   logic [7:0]                     hh_ff, hh_in;
   logic [stos_pkg::MIN_W-1:0]     m_ff, m_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic [CW-1:0]                  j_ff, j_in;
   logic [stos_pkg::MIN_W-1:0]     prev_ff, prev_in;
   logic                           hprev_ff, hprev_in;
   logic [stos_pkg::MIN_W-1:0]     cur_ff, cur_in;
   logic                           end_ff, end_in;
   logic [4:0]                     hq_ff, hq_in;
   logic [stos_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [stos_pkg::TOUT_W-1:0]    tout_ff, tout_in;
   logic [stos_pkg::RANK_W-1:0]    rank_ff, rank_in;
   logic                           last_ff, last_in;

   logic [26:0]                    key_prod;
   logic [6:0]                     mm;
   logic [5:0]                     mm_clip;
   logic [21:0]                    cur_prod;
   logic [5:0]                     cur_rem;
   logic                           idx_last;
   logic [stos_pkg::TOUT_W-1:0]    key_echo;

   // Constant-reciprocal arithmetic
   assign key_prod = 27'(key_ff) * 27'(stos_pkg::RECIP_100);
   assign mm       = 7'(key_ff - 14'(hh_ff * 8'd100));
   assign mm_clip  = (mm < 7'd60) ? mm[5:0] : 6'd59;
   assign cur_prod = 22'(cur_ff) * 22'(stos_pkg::RECIP_60);
   assign cur_rem  = 6'(cur_ff - 11'(hq_ff * 5'd30 * 2'd2));
   assign idx_last = (idx_ff + ONE_C) == count_ff;
   assign key_echo = key_ff[stos_pkg::TOUT_W-1:0];

   // Read address follows the walk or the shift
   always_comb begin
      case (state_ff)
         S_SHR:   rd_addr = AW'(j_ff - ONE_C);
         S_SHL:   rd_addr = AW'(j_ff + ONE_C);
         default: rd_addr = AW'(idx_ff);
      endcase
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = (state_ff == S_OUT);
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.time_out   = tout_ff;
   assign rsp_chan.rank_count = rank_ff;
   assign rsp_chan.last       = last_ff;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      act_in    = act_ff;
      key_in    = key_ff;
      hh_in     = hh_ff;
      m_in      = m_ff;
      idx_in    = idx_ff;
      j_in      = j_ff;
      prev_in   = prev_ff;
      hprev_in  = hprev_ff;
      cur_in    = cur_ff;
      end_in    = end_ff;
      hq_in     = hq_ff;
      status_in = status_ff;
      tout_in   = tout_ff;
      rank_in   = rank_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(j_ff);
      wr_data   = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               key_in   = req_chan.time_hhmm;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            hh_in    = key_prod[26:stos_pkg::RECIP_100_SH];
            state_in = S_DEC2;
         end
         S_DEC2: begin
            m_in     = 11'(hh_ff * 6'd60) + 11'(mm_clip);
            idx_in   = '0;
            hprev_in = 1'b0;
            end_in   = 1'b0;
            status_in = stos_pkg::ST_OK;
            tout_in   = '0;
            rank_in   = '0;
            last_in   = 1'b1;
            state_in  = S_RD;
            case (act_ff)
               stos_pkg::ACT_ADD: begin
                  if (!((hh_ff < 8'd24) && (mm < 7'd60))) begin
                     status_in = stos_pkg::ST_BAD_FMT;
                     state_in  = S_OUT;
                  end else if (count_ff == '0) begin
                     end_in   = 1'b1;
                     state_in = S_ACHK;
                  end
               end
               stos_pkg::ACT_CANCEL, stos_pkg::ACT_SEARCH, stos_pkg::ACT_RANK: begin
                  if (!((hh_ff < 8'd24) && (mm < 7'd60)) || count_ff == '0) begin
                     status_in = stos_pkg::ST_NOTFND;
                     state_in  = S_OUT;
                  end
               end
               stos_pkg::ACT_NEXT: begin
                  if (!(hh_ff < 8'd24) || count_ff == '0) begin
                     status_in = stos_pkg::ST_NOTFND;
                     state_in  = S_OUT;
                  end
               end
               stos_pkg::ACT_LAND, stos_pkg::ACT_MIN, stos_pkg::ACT_MAX,
               stos_pkg::ACT_LIST: begin
                  if (count_ff == '0) begin
                     status_in = stos_pkg::ST_EMPTY;
                     state_in  = S_OUT;
                  end else if (act_ff == stos_pkg::ACT_MAX) begin
                     idx_in = count_ff - ONE_C;
                  end
               end
               default: begin
                  status_in = stos_pkg::ST_BAD_FMT;
                  state_in  = S_OUT;
               end
            endcase
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            cur_in = rd_data;
            case (act_ff)
               stos_pkg::ACT_ADD: begin
                  if (rd_data < m_ff) begin
                     prev_in  = rd_data;
                     hprev_in = 1'b1;
                     idx_in   = idx_ff + ONE_C;
                     end_in   = idx_last;
                     state_in = idx_last ? S_ACHK : S_RD;
                  end else begin
                     state_in = S_ACHK;
                  end
               end
               stos_pkg::ACT_CANCEL, stos_pkg::ACT_SEARCH, stos_pkg::ACT_RANK: begin
                  if (rd_data == m_ff) begin
                     tout_in = key_echo;
                     if (act_ff == stos_pkg::ACT_RANK) begin
                        rank_in = stos_pkg::RANK_W'(idx_ff) + stos_pkg::RANK_W'(1);
                     end
                     if (act_ff == stos_pkg::ACT_CANCEL) begin
                        j_in     = idx_ff;
                        state_in = S_SHL;
                     end else begin
                        state_in = S_OUT;
                     end
                  end else if (idx_last) begin
                     status_in = stos_pkg::ST_NOTFND;
                     state_in  = S_OUT;
                  end else begin
                     idx_in   = idx_ff + ONE_C;
                     state_in = S_RD;
                  end
               end
               stos_pkg::ACT_NEXT: begin
                  if (rd_data > m_ff) begin
                     state_in = S_CV1;
                  end else if (idx_last) begin
                     status_in = stos_pkg::ST_NOTFND;
                     state_in  = S_OUT;
                  end else begin
                     idx_in   = idx_ff + ONE_C;
                     state_in = S_RD;
                  end
               end
               stos_pkg::ACT_LAND: begin
                  j_in     = '0;
                  state_in = S_SHL;
               end
               stos_pkg::ACT_LIST: begin
                  last_in  = idx_last;
                  state_in = S_CV1;
               end
               default: begin
                  state_in = S_CV1;
               end
            endcase
         end
         S_ACHK: begin
            state_in = S_OUT;
            if (hprev_ff && ((m_ff - prev_ff) < min_gap)) begin
               status_in = stos_pkg::ST_SPACING;
            end else if (!end_ff && ((cur_ff - m_ff) < min_gap)) begin
               status_in = stos_pkg::ST_SPACING;
            end else if (!end_ff && (cur_ff == m_ff)) begin
               tout_in = key_echo;
            end else if (count_ff >= CAP_C) begin
               status_in = stos_pkg::ST_FULL;
            end else if (count_ff == idx_ff) begin
               state_in = S_INS;
            end else begin
               j_in     = count_ff;
               state_in = S_SHR;
            end
         end
         S_SHR: begin
            state_in = S_SHW;
         end
         S_SHW: begin
            // Move one entry up
            wr_en    = 1'b1;
            j_in     = j_ff - ONE_C;
            state_in = ((j_ff - ONE_C) == idx_ff) ? S_INS : S_SHR;
         end
         S_INS: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = m_ff;
            count_in = count_ff + ONE_C;
            tout_in  = key_echo;
            state_in = S_OUT;
         end
         S_SHL: begin
            if ((j_ff + ONE_C) < count_ff) begin
               state_in = S_SLW;
            end else begin
               count_in = count_ff - ONE_C;
               state_in = (act_ff == stos_pkg::ACT_LAND) ? S_CV1 : S_OUT;
            end
         end
         S_SLW: begin
            // Move one entry down
            wr_en    = 1'b1;
            j_in     = j_ff + ONE_C;
            state_in = S_SHL;
         end
         S_CV1: begin
            hq_in    = cur_prod[20:stos_pkg::RECIP_60_SH];
            state_in = S_CV2;
         end
         S_CV2: begin
            tout_in  = 12'(hq_ff * 7'd100) + 12'(cur_rem);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               if (act_ff == stos_pkg::ACT_LIST && !last_ff && status_ff == stos_pkg::ST_OK) begin
                  idx_in   = idx_ff + ONE_C;
                  state_in = S_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      key_ff    <= key_in;
      hh_ff     <= hh_in;
      m_ff      <= m_in;
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      prev_ff   <= prev_in;
      hprev_ff  <= hprev_in;
      cur_ff    <= cur_in;
      end_ff    <= end_in;
      hq_ff     <= hq_in;
      status_ff <= status_in;
      tout_ff   <= tout_in;
      rank_ff   <= rank_in;
      last_ff   <= last_in;
   end

endmodule
`default_nettype wire

// ===== src/spaced_time_ordered_set.sv =====
// Commands run one at a time: the next is taken only after the last result word
// of the current one has been taken on rsp_chan.ready. List gives one word per
// stored time, each built in S_RD, S_EV, S_CV1 and S_CV2 and held in S_OUT until
// rsp_chan.ready. The walk and the shifts spend a read state and an evaluate or
// write state on each entry.
// Reset: synchronous, clears the entry count and the min gap; table stays as is.
`default_nettype none
module spaced_time_ordered_set #(
   parameter int CAPACITY = stos_pkg::CAPACITY_DEF
) (
   input wire logic     clock,
   input wire logic     reset,
   stos_csr_if.sink     csr_chan,
   stos_req_if.sink     req_chan,
   stos_rsp_if.source   rsp_chan
);

   localparam int AW = $clog2(CAPACITY);

   logic [stos_pkg::GAP_W-1:0] gap_ff;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [stos_pkg::MIN_W-1:0]  wr_data;
   logic [AW-1:0]               rd_addr;
   logic [stos_pkg::MIN_W-1:0]  rd_data;

   // Hold the gap register
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (csr_chan.valid) begin
         gap_ff <= csr_chan.min_gap;
      end
   end

   stos_core #(.CAPACITY(CAPACITY)) u_core (
      .clock    (clock),
      .reset    (reset),
      .min_gap  (gap_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   stos_mem #(.DEPTH(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

// ===== src/stos_checker.sv =====
// Port checker for the spaced time set, bound to the top level.
`default_nettype none
`include "spaced_time_ordered_set_defines.svh"
module stos_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic [stos_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [stos_pkg::TOUT_W-1:0]    rsp_time_out,
   input wire logic [stos_pkg::RANK_W-1:0]    rsp_rank_count,
   input wire logic                           rsp_last
);

   logic take_req;
   logic rsp_ok;
   logic rank_shown;
   logic rsp_bad;

   // Decode the handshake and the word's status
   assign take_req   = req_valid && req_ready;
   assign rsp_ok     = rsp_status == stos_pkg::ST_OK;
   assign rank_shown = rsp_valid && rsp_rank_count != '0;
   assign rsp_bad    = rsp_valid && !rsp_ok;

   `STOS_ASSERT(busy_while_out, rsp_valid |-> !req_ready, "ready while a word waits")
   `STOS_ASSERT(busy_after_take, take_req |=> !req_ready, "ready right after a command")
   `STOS_ASSERT(rank_only_ok, rank_shown |-> rsp_ok, "rank on a failed word")
   `STOS_ASSERT(fail_is_final, rsp_bad |-> (rsp_last && rsp_time_out == '0), "bad word")
   `STOS_ASSERT_ALWAYS(quiet_after_reset, reset |=> !rsp_valid, "word shown after reset")

endmodule

bind spaced_time_ordered_set stos_checker u_stos_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_status     (rsp_chan.status),
   .rsp_time_out   (rsp_chan.time_out),
   .rsp_rank_count (rsp_chan.rank_count),
   .rsp_last       (rsp_chan.last)
);
`default_nettype wire
